// File: src/sha1_message_hasher_core_defines.svh
// Assertion macros for the SHA-1 hasher core; clocked on clk_i, disabled while rst_ni is low.
`ifndef SHA1_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define SMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SMH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMH_ASSERT_IMP(lbl, ante, cons, msg)
`define SMH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/sha1mh_pkg.sv
// Types, constants and round helpers shared by the SHA-1 hasher core.
`default_nettype none

package sha1mh_pkg;

  // Default width of the running bit-length counter
  localparam int unsigned LenBitsDefault = 64;

  // Digest words and index of the last one
  localparam int unsigned DigestWords = 5;
  localparam logic [2:0]  LastWordIdx = 3'(DigestWords - 1);

  // Index of the last round in a block
  localparam logic [6:0] LastRound = 7'd79;

  // Padding marker byte
  localparam logic [7:0] PadMarker = 8'h80;

  // Initial chaining values h0..h4
  localparam logic [31:0] ChainIv [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Input word: one message byte plus framing
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_word_t;

  // Output word: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Round constant by round number
  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  // Round boolean function by round number
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: src/sha1_message_hasher_core.sv
// SHA-1 hasher core: byte intake, padding sequencer and one-round-per-cycle compression.
//
//   channel | dir | payload     | handshake
//   --------+-----+-------------+------------------------------
//   in      | in  | in_word_i   | in_valid_i / in_stall_o
//   out     | out | out_word_o  | out_valid_o / out_stall_i
//
// A byte that does not complete a block leaves the core idle. A byte that completes a
// block adds 80 rounds through the shared round adder, then one chain add.
// The last word pads one byte a cycle up to byte 56 (a fill past 55 first pads out
// and compresses another block), then closes the pad, appends the length, compresses
// the final block and emits five digest words, one per cycle unless out_stall_i
// holds them. No input is taken while the block pads, compresses or emits.
`default_nettype none

`include "sha1_message_hasher_core_defines.svh"

module sha1_message_hasher_core
  import sha1mh_pkg::*;
#(
  parameter int unsigned LENGTH_COUNTER_BITS = LenBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  localparam int unsigned BlkBits = 512;

  // Control registers
  state_e                         state_q, state_d;
  logic [5:0]                     fill_q, fill_d;
  logic [LENGTH_COUNTER_BITS-1:0] len_q, len_d;
  logic [31:0]                    chain_q [DigestWords];
  logic [31:0]                    chain_d [DigestWords];
  logic [6:0]                     round_q, round_d;
  logic                           pad_first_q, pad_first_d;
  logic                           pend_last_q, pend_last_d;
  logic                           final_q, final_d;
  logic [2:0]                     oidx_q, oidx_d;

  // Payload registers
  logic [BlkBits-1:0] blk_q, blk_d;
  logic [31:0]        a_q, b_q, c_q, d_q, e_q;
  logic [31:0]        a_d, b_d, c_d, d_d, e_d;

  logic        in_acc, out_acc;
  logic [63:0] len_ext;
  logic [31:0] w0, w2, w8, w13, w_mix, w_new, t_sum;
  logic [5:0]  fill_inc;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_acc  = out_valid_o & ~out_stall_i;
  assign len_ext  = 64'(len_q);
  assign fill_inc = fill_q + 6'd1;

  // Message schedule taps: window holds w[t..t+15], w[t] in the top word
  assign w0    = blk_q[BlkBits-1       -: 32];
  assign w2    = blk_q[BlkBits-1-32*2  -: 32];
  assign w8    = blk_q[BlkBits-1-32*8  -: 32];
  assign w13   = blk_q[BlkBits-1-32*13 -: 32];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Shared round adder
  assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q) + e_q
               + round_k(round_q) + w0;

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    chain_d     = chain_q;
    round_d     = round_q;
    pad_first_d = pad_first_q;
    pend_last_d = pend_last_q;
    final_d     = final_q;
    oidx_d      = oidx_q;
    blk_d       = blk_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_last_d = in_word_i.last;
          pad_first_d = 1'b1;
          final_d     = 1'b0;
          if (in_word_i.has_byte) begin
            blk_d  = {blk_q[BlkBits-9:0], in_word_i.data_byte};
            fill_d = fill_inc;
            len_d  = len_q + LENGTH_COUNTER_BITS'(8);
          end
          if (in_word_i.has_byte && fill_inc == 6'd0) begin
            state_d = ST_ROUND;
            round_d = '0;
            a_d = chain_q[0];
            b_d = chain_q[1];
            c_d = chain_q[2];
            d_d = chain_q[3];
            e_d = chain_q[4];
          end else if (in_word_i.last) begin
            state_d = ST_PAD;
          end
        end
      end

      // One pad byte per cycle until 56 bytes sit in the block; a full block compresses first
      ST_PAD: begin
        if (!pad_first_q && fill_q == 6'd56) begin
          state_d = ST_LEN;
        end else begin
          blk_d       = {blk_q[BlkBits-9:0], (pad_first_q ? PadMarker : 8'h00)};
          fill_d      = fill_inc;
          pad_first_d = 1'b0;
          if (fill_inc == 6'd0) begin
            state_d = ST_ROUND;
            round_d = '0;
            a_d = chain_q[0];
            b_d = chain_q[1];
            c_d = chain_q[2];
            d_d = chain_q[3];
            e_d = chain_q[4];
          end
        end
      end

      // Big-endian bit length closes the final block
      ST_LEN: begin
        blk_d   = {blk_q[BlkBits-65:0], len_ext};
        fill_d  = '0;
        final_d = 1'b1;
        state_d = ST_ROUND;
        round_d = '0;
        a_d = chain_q[0];
        b_d = chain_q[1];
        c_d = chain_q[2];
        d_d = chain_q[3];
        e_d = chain_q[4];
      end

      ST_ROUND: begin
        a_d   = t_sum;
        b_d   = a_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        d_d   = c_q;
        e_d   = d_q;
        blk_d = {blk_q[BlkBits-33:0], w_new};
        if (round_q == LastRound) begin
          state_d = ST_ADD;
        end else begin
          round_d = round_q + 7'd1;
        end
      end

      ST_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        if (final_q) begin
          state_d = ST_OUT;
          oidx_d  = '0;
        end else if (pend_last_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Five digest words, then back to a fresh message
      ST_OUT: begin
        if (out_acc) begin
          if (oidx_q == LastWordIdx) begin
            state_d     = ST_IDLE;
            chain_d     = ChainIv;
            len_d       = '0;
            fill_d      = '0;
            pend_last_d = 1'b0;
            final_d     = 1'b0;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      chain_q     <= ChainIv;
      round_q     <= '0;
      pad_first_q <= 1'b0;
      pend_last_q <= 1'b0;
      final_q     <= 1'b0;
      oidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      chain_q     <= chain_d;
      round_q     <= round_d;
      pad_first_q <= pad_first_d;
      pend_last_q <= pend_last_d;
      final_q     <= final_d;
      oidx_q      <= oidx_d;
    end
  end

  // Block window and working variables
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  // Ports
  assign in_stall_o             = (state_q != ST_IDLE);
  assign out_valid_o            = (state_q == ST_OUT);
  assign out_word_o.digest_word = chain_q[oidx_q];
  assign out_word_o.word_index  = oidx_q;
  assign out_word_o.last_word   = (oidx_q == LastWordIdx);

  // Checks
  `SMH_ASSERT_IMP(a_no_intake_while_out, out_valid_o, in_stall_o, "input taken during digest")
  `SMH_ASSERT_NXT(a_idle_after_last, out_acc && oidx_q == LastWordIdx, !in_stall_o, "not idle")
  `SMH_ASSERT_IMP(a_round_range, state_q == ST_ROUND, round_q <= LastRound, "round overrun")
  `SMH_ASSERT_IMP(a_out_idx_range, out_valid_o, oidx_q <= LastWordIdx, "digest index overrun")

endmodule

`default_nettype wire
